// ----- rtl/bilinear_image_scaler_macros.svh -----
// Assertion macros used by the scaler top level.
`ifndef BILINEAR_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BIS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bilinear_image_scaler: check failed");

// Next-cycle implication.
`define BIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bilinear_image_scaler: check failed");

`endif

// ----- rtl/bis_pkg.sv -----
// Package: types, constants and blend function of the image scaler.
`timescale 1ns / 1ps
package bis_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int COORD_W = 9;
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 10;
  localparam int STEP_W  = 26;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 26;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = COORD_W + STEP_W;

  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP_X     = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEP_Y     = 3'd6;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;
  } req_t;

  typedef struct packed {
    logic              mode;
    logic [DIM_W-1:0]  src_width;
    logic [DIM_W-1:0]  src_height;
    logic [DIM_W-1:0]  dst_width;
    logic [DIM_W-1:0]  dst_height;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } cfg_t;

  // Sideband that travels alongside the frame store read.
  typedef struct packed {
    logic              req;
    logic              err;
    logic              blend;
    logic              x0_odd;
    logic              y0_odd;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } meta_t;

  // Result of the horizontal blend pass.
  typedef struct packed {
    logic              req;
    logic              err;
    logic              blend;
    logic [FRAC_W-1:0] fy;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  bot;
  } part_t;

  // p*(1-f) + q*f, truncated, written as p + (q-p)*f.
  function automatic logic [PIX_W-1:0] lerp(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q,
                                            logic [FRAC_W-1:0] f);
    logic signed [PIX_W:0]              d;
    logic signed [PIX_W+FRAC_W+1:0]     s;
    d = $signed({1'b0, q}) - $signed({1'b0, p});
    s = $signed({2'b00, p, {FRAC_W{1'b0}}}) + d * $signed({1'b0, f});
    return s[PIX_W+FRAC_W-1:FRAC_W];
  endfunction

endpackage

// ----- rtl/bis_if.sv -----
// Interfaces: request and result channels of the image scaler.
`timescale 1ns / 1ps
interface bis_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bis_pkg::COORD_W-1:0] col;
  logic [bis_pkg::COORD_W-1:0] row;
  logic [bis_pkg::PIX_W-1:0]   pixel_in;
  modport source (output valid, op, col, row, pixel_in, input ready);
  modport sink   (input valid, op, col, row, pixel_in, output ready);
endinterface

interface bis_res_if;
  logic                     valid;
  logic                     ready;
  logic [bis_pkg::PIX_W-1:0] pixel_out;
  logic                     range_error;
  modport source (output valid, pixel_out, range_error, input ready);
  modport sink   (input valid, pixel_out, range_error, output ready);
endinterface

// ----- rtl/bilinear_image_scaler.sv -----
// Top level of the bilinear / nearest-neighbour image scaler.
//
// Channels: req_i takes words of op, col, row and pixel_in. A write word
// (op 0) stores pixel_in in the frame store at (row, col); a request word
// (op 1) asks for the destination pixel (col, row). res_o returns one word
// per request: pixel_out and range_error, which flags a request outside the
// destination size (pixel_out is then zero). Writes return nothing.
// The configuration port writes register cfg_idx_i with cfg_data_i while
// cfg_we_i is high; write it only while the pipeline is empty.
// Timing: one word enters per cycle unless stalled. A request's result is on
// res_o after the input register, product, frame store read, the horizontal
// blend, and the vertical blend into the output register.
// The frame store is split into four banks by row and column parity, so the
// four neighbours are read in the same cycle.
// Stall: the whole pipeline holds while res_o is valid and not taken;
// req_i.ready falls in the same cycle. Nothing is dropped or repeated.
// Reset: registers return to bilinear mode, 512 x 512 sizes and unit steps;
// the pipeline empties. The frame store is not cleared.
`timescale 1ns / 1ps
`include "bilinear_image_scaler_macros.svh"
module bilinear_image_scaler #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bis_req_if.sink                     req_i,
  bis_res_if.source                   res_o,
  input  logic                        cfg_we_i,
  input  logic [bis_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [bis_pkg::CFG_W-1:0]   cfg_data_i
);
  localparam int HALF_W = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
  localparam int DEPTH  = HALF_W * HALF_H;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;

  bis_pkg::cfg_t             cfg_q;
  bis_pkg::req_t             in_word;
  bis_pkg::meta_t            meta;
  bis_pkg::part_t            part;
  logic                      en;
  logic [AW-1:0]             rd_addr [4];
  logic [3:0]                wr_en;
  logic [AW-1:0]             wr_addr;
  logic [bis_pkg::PIX_W-1:0] wr_data;
  logic [bis_pkg::PIX_W-1:0] bank_rd [4];
  logic                      res_valid_q;
  logic [bis_pkg::PIX_W-1:0] pixel_q, pixel_d;
  logic                      err_q;

  // Advance everything when the output register is free or being taken.
  assign en          = !res_valid_q || res_o.ready;
  assign req_i.ready = en;

  assign in_word.op       = req_i.op;
  assign in_word.col      = req_i.col;
  assign in_word.row      = req_i.row;
  assign in_word.pixel_in = req_i.pixel_in;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= 1'b1;
      cfg_q.src_width  <= bis_pkg::DIM_W'(512);
      cfg_q.src_height <= bis_pkg::DIM_W'(512);
      cfg_q.dst_width  <= bis_pkg::DIM_W'(512);
      cfg_q.dst_height <= bis_pkg::DIM_W'(512);
      cfg_q.step_x     <= bis_pkg::STEP_W'(65536);
      cfg_q.step_y     <= bis_pkg::STEP_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bis_pkg::REG_MODE:       cfg_q.mode       <= cfg_data_i[0];
        bis_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data_i[bis_pkg::DIM_W-1:0];
        bis_pkg::REG_STEP_X:     cfg_q.step_x     <= cfg_data_i[bis_pkg::STEP_W-1:0];
        bis_pkg::REG_STEP_Y:     cfg_q.step_y     <= cfg_data_i[bis_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  bis_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (req_i.valid),
    .in_word_i  (in_word),
    .cfg_i      (cfg_q),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .meta_o     (meta)
  );

  // Four parity banks; bank index is {row[0], col[0]}. Reads hold on stall.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    bis_ram #(
      .WIDTH (bis_pkg::PIX_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en[b]),
      .waddr_i (wr_addr),
      .wdata_i (wr_data),
      .re_i    (en),
      .raddr_i (rd_addr[b]),
      .rdata_o (bank_rd[b])
    );
  end

  bis_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .meta_i (meta),
    .bank_i (bank_rd),
    .part_o (part)
  );

  // Vertical blend, then the output register. A zero fraction keeps the
  // upper row, so the lower row is never looked at.
  always_comb begin
    if (part.err) begin
      pixel_d = '0;
    end else if (part.blend && part.fy != '0) begin
      pixel_d = bis_pkg::lerp(part.top, part.bot, part.fy);
    end else begin
      pixel_d = part.top;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= part.req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_q <= pixel_d;
      err_q   <= part.err;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.pixel_out   = pixel_q;
  assign res_o.range_error = err_q;

  `BIS_ASSERT_IMPL(a_err_zero, res_o.valid && res_o.range_error, res_o.pixel_out == '0)
  `BIS_ASSERT_IMPL(a_stall_blocks, res_o.valid && !res_o.ready, !req_i.ready)
  `BIS_ASSERT_NEXT(a_part_reaches_out, en && part.req, res_o.valid)
endmodule

// ----- rtl/bis_ram.sv -----
// Generic single write, single registered read RAM.
`timescale 1ns / 1ps
module bis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/bis_coord.sv -----
// Coordinate stages: source mapping, edge checks and bank addressing.
`timescale 1ns / 1ps
module bis_coord #(
  parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
  localparam int HALF_W    = (MAX_WIDTH + 1) / 2,
  localparam int HALF_H    = (MAX_HEIGHT + 1) / 2,
  localparam int DEPTH     = HALF_W * HALF_H,
  localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  bis_pkg::req_t              in_word_i,
  input  bis_pkg::cfg_t              cfg_i,
  output logic [AW-1:0]              rd_addr_o [4],
  output logic [3:0]                 wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [bis_pkg::PIX_W-1:0]  wr_data_o,
  output bis_pkg::meta_t             meta_o
);
  localparam int IX_W  = bis_pkg::PROD_W - bis_pkg::FRAC_W;
  localparam int CMP_W = IX_W + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);

  logic                        s1_valid_q;
  bis_pkg::req_t               s1_word_q;
  logic                        s2_valid_q;
  bis_pkg::req_t               s2_word_q;
  logic                        s2_err_q, s2_err_d;
  logic [bis_pkg::PROD_W-1:0]  s2_px_q, s2_px_d, s2_py_q, s2_py_d;
  bis_pkg::meta_t              meta_q, meta_d;

  logic [CMP_W-1:0] sw, sh, ix, iy, cx, cy, x0_full, y0_full;
  logic [CW-1:0]    x0;
  logic [RW-1:0]    y0;
  logic [CW:0]      c_sel [4];
  logic [RW:0]      r_sel [4];
  logic [1:0]       wbank;
  logic             wr_ok;

  // Stage one: product and destination bound check.
  always_comb begin
    s2_err_d = (bis_pkg::DIM_W'(s1_word_q.col) >= cfg_i.dst_width) ||
               (bis_pkg::DIM_W'(s1_word_q.row) >= cfg_i.dst_height);
    s2_px_d  = bis_pkg::PROD_W'(s1_word_q.col) * bis_pkg::PROD_W'(cfg_i.step_x);
    s2_py_d  = bis_pkg::PROD_W'(s1_word_q.row) * bis_pkg::PROD_W'(cfg_i.step_y);
  end

  // Stage two: saturate, decide blend, address the four banks.
  always_comb begin
    if (cfg_i.src_width == '0) begin
      sw = CMP_W'(1);
    end else if (CMP_W'(cfg_i.src_width) > CMP_W'(MAX_WIDTH)) begin
      sw = CMP_W'(MAX_WIDTH);
    end else begin
      sw = CMP_W'(cfg_i.src_width);
    end
    if (cfg_i.src_height == '0) begin
      sh = CMP_W'(1);
    end else if (CMP_W'(cfg_i.src_height) > CMP_W'(MAX_HEIGHT)) begin
      sh = CMP_W'(MAX_HEIGHT);
    end else begin
      sh = CMP_W'(cfg_i.src_height);
    end
    ix = CMP_W'(s2_px_q[bis_pkg::PROD_W-1:bis_pkg::FRAC_W]);
    iy = CMP_W'(s2_py_q[bis_pkg::PROD_W-1:bis_pkg::FRAC_W]);
    cx = ix + CMP_W'(s2_px_q[bis_pkg::FRAC_W-1:0] != '0);
    cy = iy + CMP_W'(s2_py_q[bis_pkg::FRAC_W-1:0] != '0);
    x0_full = (ix >= sw) ? sw - CMP_W'(1) : ix;
    y0_full = (iy >= sh) ? sh - CMP_W'(1) : iy;
    x0 = x0_full[CW-1:0];
    y0 = y0_full[RW-1:0];

    meta_d.req    = s2_valid_q && (s2_word_q.op == bis_pkg::OP_REQUEST);
    meta_d.err    = s2_err_q;
    meta_d.blend  = cfg_i.mode && (cx < sw) && (cy < sh);
    meta_d.x0_odd = x0[0];
    meta_d.y0_odd = y0[0];
    meta_d.fx     = s2_px_q[bis_pkg::FRAC_W-1:0];
    meta_d.fy     = s2_py_q[bis_pkg::FRAC_W-1:0];

    for (int b = 0; b < 4; b++) begin
      c_sel[b] = (x0[0] == b[0]) ? {1'b0, x0} : {1'b0, x0} + (CW+1)'(1);
      r_sel[b] = (y0[0] == b[1]) ? {1'b0, y0} : {1'b0, y0} + (RW+1)'(1);
      rd_addr_o[b] = AW'(32'(r_sel[b][RW:1]) * 32'(HALF_W) + 32'(c_sel[b][CW:1]));
    end

    wbank = {s2_word_q.row[0], s2_word_q.col[0]};
    wr_ok = en_i && s2_valid_q && (s2_word_q.op == bis_pkg::OP_WRITE) &&
            (32'(s2_word_q.col) < 32'(MAX_WIDTH)) && (32'(s2_word_q.row) < 32'(MAX_HEIGHT));
    for (int b = 0; b < 4; b++) begin
      wr_en_o[b] = wr_ok && (wbank == 2'(b));
    end
    wr_addr_o = AW'(32'(s2_word_q.row[bis_pkg::COORD_W-1:1]) * 32'(HALF_W) +
                    32'(s2_word_q.col[bis_pkg::COORD_W-1:1]));
    wr_data_o = s2_word_q.pixel_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      meta_q     <= '0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      meta_q     <= meta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_word_q <= in_word_i;
      s2_word_q <= s1_word_q;
      s2_err_q  <= s2_err_d;
      s2_px_q   <= s2_px_d;
      s2_py_q   <= s2_py_d;
    end
  end

  assign meta_o = meta_q;
endmodule

// ----- rtl/bis_blend.sv -----
// Horizontal blend stage: route bank words to neighbours and blend each row.
`timescale 1ns / 1ps
module bis_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  bis_pkg::meta_t            meta_i,
  input  logic [bis_pkg::PIX_W-1:0] bank_i [4],
  output bis_pkg::part_t            part_o
);
  logic [bis_pkg::PIX_W-1:0] p00, p01, p10, p11;
  bis_pkg::part_t            part_q, part_d;

  always_comb begin
    p00 = bank_i[{meta_i.y0_odd, meta_i.x0_odd}];
    p01 = bank_i[{meta_i.y0_odd, !meta_i.x0_odd}];
    p10 = bank_i[{!meta_i.y0_odd, meta_i.x0_odd}];
    p11 = bank_i[{!meta_i.y0_odd, !meta_i.x0_odd}];
    part_d.req   = meta_i.req;
    part_d.err   = meta_i.err;
    part_d.blend = meta_i.blend;
    part_d.fy    = meta_i.fy;
    // Without blend the floored sample passes on the top lane. A zero fraction
    // keeps the left column, so the right neighbour is never looked at.
    part_d.top   = (meta_i.blend && meta_i.fx != '0) ? bis_pkg::lerp(p00, p01, meta_i.fx) : p00;
    part_d.bot   = (meta_i.fx != '0) ? bis_pkg::lerp(p10, p11, meta_i.fx) : p10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else if (en_i) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;
endmodule
